>>> hdl/vnorm_pkg.sv
`timescale 1ns / 1ps
package vnorm_pkg;

    // Component and fraction widths of the words
    localparam int COMP_W = 16;
    localparam int FRAC_W = 15;
    localparam int MAG_W  = COMP_W + 1;
    localparam int SUM_W  = 2 * COMP_W;
    localparam int UNIT_W = FRAC_W + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
    } in_word_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic                     zero_length;
    } out_word_t;

    // Classified vector handed from the front to the back
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [SUM_W-1:0]      sum;
    } mid_word_t;

endpackage

>>> hdl/vnorm_front.sv
`timescale 1ns / 1ps
module vnorm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  vnorm_pkg::in_word_t in_word,
    output logic                mid_push,
    input  logic                mid_full,
    output vnorm_pkg::mid_word_t mid_word
);
    localparam int CW = vnorm_pkg::COMP_W;
    localparam int MW = vnorm_pkg::MAG_W;
    localparam int SW = vnorm_pkg::SUM_W;

    logic                  a_valid_reg;
    logic [2:0][MW-1:0]    a_mag_reg;
    logic [2:0]            a_neg_reg;
    logic                  b_valid_reg;
    logic [2:0][MW-1:0]    b_mag_reg;
    logic [2:0]            b_neg_reg;
    logic [2:0][SW-1:0]    b_sq_reg;
    logic [2:0][CW-1:0]    comp;
    logic [2:0][MW-1:0]    mag_next;
    logic                  adv;

    // Advance while the last stage is empty or the queue has room
    assign adv      = !b_valid_reg || !mid_full;
    assign full     = !adv;
    assign mid_push = b_valid_reg && !mid_full;

    assign comp[0] = in_word.in_x;
    assign comp[1] = in_word.in_y;
    assign comp[2] = in_word.in_z;

    // Take magnitudes of the two's complement components
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (comp[k][CW-1])
                mag_next[k] = ~{1'b1, comp[k]} + MW'(1);
            else
                mag_next[k] = {1'b0, comp[k]};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Hold magnitudes, then squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mag_reg <= mag_next;
            for (int k = 0; k < 3; k++)
                a_neg_reg[k] <= comp[k][CW-1];
            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
            for (int k = 0; k < 3; k++)
                b_sq_reg[k] <= SW'(a_mag_reg[k] * a_mag_reg[k]);
        end
    end

    assign mid_word.mag = b_mag_reg;
    assign mid_word.neg = b_neg_reg;
    assign mid_word.sum = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

endmodule

>>> hdl/vnorm_queue.sv
`timescale 1ns / 1ps
module vnorm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  vnorm_pkg::mid_word_t push_word,
    input  logic                 pop,
    output logic                 empty,
    output vnorm_pkg::mid_word_t pop_word
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    vnorm_pkg::mid_word_t mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_word = mem[rd_ptr_reg];

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_word;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

endmodule

>>> hdl/vnorm_back.sv
`timescale 1ns / 1ps
module vnorm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mid_empty,
    output logic                 mid_pop,
    input  vnorm_pkg::mid_word_t mid_word,
    output logic                 empty,
    input  logic                 pop,
    output vnorm_pkg::out_word_t out_word
);
    localparam int CW = vnorm_pkg::COMP_W;
    localparam int FB = vnorm_pkg::FRAC_W;
    localparam int MW = vnorm_pkg::MAG_W;
    localparam int SW = vnorm_pkg::SUM_W;
    localparam int QW = vnorm_pkg::UNIT_W;
    localparam int DW = MW + FB;
    localparam logic [QW-1:0] UNIT_MAX = {1'b0, {FB{1'b1}}};

    logic adv;

    // Square root stages, one root bit each
    logic                s_v    [0:CW];
    logic [SW-1:0]       s_rem  [0:CW];
    logic [CW-1:0]       s_root [0:CW];
    logic [2:0][MW-1:0]  s_mag  [0:CW];
    logic [2:0]          s_neg  [0:CW];

    // Divider stages, one quotient bit each, three lanes
    logic                d_v    [0:QW];
    logic [CW-1:0]       d_len  [0:QW];
    logic [2:0][DW-1:0]  d_rem  [0:QW];
    logic [2:0][QW-1:0]  d_q    [0:QW];
    logic [2:0]          d_neg  [0:QW];

    logic                out_valid_reg;
    vnorm_pkg::out_word_t out_word_reg;
    vnorm_pkg::out_word_t out_word_next;

    // Stall the whole back pipe only while the result waits
    assign adv     = !out_valid_reg || pop;
    assign mid_pop = adv && !mid_empty;
    assign empty   = !out_valid_reg;
    assign out_word = out_word_reg;

    assign s_v[0]    = !mid_empty;
    assign s_rem[0]  = mid_word.sum;
    assign s_root[0] = '0;
    assign s_mag[0]  = mid_word.mag;
    assign s_neg[0]  = mid_word.neg;

    for (genvar g = 0; g < CW; g++)
    begin : g_sqrt
        localparam int BI = CW - 1 - g;
        logic [SW:0] trial;
        logic        take;

        // Cost of setting this root bit: 2^(i+1)*r + 4^i
        assign trial = ((SW+1)'(s_root[g]) << (BI + 1)) + ((SW+1)'(1) << (2 * BI));
        assign take  = ({1'b0, s_rem[g]} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_v[g+1] <= 1'b0;
            else if (adv)
                s_v[g+1] <= s_v[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_rem[g+1]  <= take ? SW'({1'b0, s_rem[g]} - trial) : s_rem[g];
                s_root[g+1] <= take ? (s_root[g] | (CW'(1) << BI)) : s_root[g];
                s_mag[g+1]  <= s_mag[g];
                s_neg[g+1]  <= s_neg[g];
            end
        end
    end

    assign d_v[0]   = s_v[CW];
    assign d_len[0] = s_root[CW];
    assign d_neg[0] = s_neg[CW];
    assign d_q[0]   = '0;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            d_rem[0][k] = DW'(s_mag[CW][k]) << FB;
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        localparam int QB = FB - g;
        logic [DW-1:0]      dsub;
        logic [2:0][DW-1:0] rem_next;
        logic [2:0][QW-1:0] q_next;

        assign dsub = DW'(d_len[g]) << QB;

        // Subtract shifted length where it fits
        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (d_rem[g][k] >= dsub)
                begin
                    rem_next[k] = d_rem[g][k] - dsub;
                    q_next[k]   = d_q[g][k] | (QW'(1) << QB);
                end
                else
                begin
                    rem_next[k] = d_rem[g][k];
                    q_next[k]   = d_q[g][k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v[g+1] <= 1'b0;
            else if (adv)
                d_v[g+1] <= d_v[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_rem[g+1] <= rem_next;
                d_q[g+1]   <= q_next;
                d_len[g+1] <= d_len[g];
                d_neg[g+1] <= d_neg[g];
            end
        end
    end

    // Apply sign, saturate, and drop to zero for a zero length
    always_comb
    begin
        logic [2:0][QW-1:0] u;
        logic               zl;
        zl = (d_len[QW] == '0);
        for (int k = 0; k < 3; k++)
        begin
            if (zl)
                u[k] = '0;
            else if (d_neg[QW][k])
                u[k] = QW'(0) - d_q[QW][k];
            else if (d_q[QW][k] > UNIT_MAX)
                u[k] = UNIT_MAX;
            else
                u[k] = d_q[QW][k];
        end
        out_word_next.unit_x      = u[0];
        out_word_next.unit_y      = u[1];
        out_word_next.unit_z      = u[2];
        out_word_next.zero_length = zl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_v[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_word_reg <= out_word_next;
    end

endmodule

>>> hdl/vector3_normalize_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake          Word
// input     push / full        in_word  (in_x, in_y, in_z)
// result    pop / empty        out_word (unit_x, unit_y, unit_z, zero_length)
//
// One vector is taken per cycle while full is low; a result passes through
// 2 front stages, 1 queue write, 16 root stages, 16 divide stages and the
// output register before it can be popped.
// A 4-word queue parts the squaring front from the root/divide back, so
// each side stalls on its own; the back holds as a whole while a result waits.
// Reset clears all valid bits and the queue.
module vector3_normalize_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  vnorm_pkg::in_word_t  in_word,
    output logic                 empty,
    input  logic                 pop,
    output vnorm_pkg::out_word_t out_word
);
    logic                 f_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    vnorm_pkg::mid_word_t f_word;
    vnorm_pkg::mid_word_t q_word;

    vnorm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .mid_push (f_push),
        .mid_full (q_full),
        .mid_word (f_word)
    );

    vnorm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .full      (q_full),
        .push_word (f_word),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_word  (q_word)
    );

    vnorm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (q_empty),
        .mid_pop   (q_pop),
        .mid_word  (q_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

endmodule
